// File: design/scrp_pkg.sv
// Shared types and constants for the serial camera response parser.
// Holds the beat payload structs, the response and status codes and the byte tables.
// No dependencies; the engine, the top level and the testbench import it.
`default_nettype none

package scrp_pkg;

   // Input beat operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // Expected response kinds
   localparam logic [1:0] KIND_RESET_ACK = 2'd0;
   localparam logic [1:0] KIND_BASIC_ACK = 2'd1;
   localparam logic [1:0] KIND_GET_SIZE  = 2'd2;
   localparam logic [1:0] KIND_DATA      = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_HEADER_BAD  = 2'd1;
   localparam logic [1:0] STATUS_FOOTER_BAD  = 2'd2;
   localparam logic [1:0] STATUS_INIT_TIMEOUT = 2'd3;

   // Configuration register indexes
   localparam logic CSR_CHUNK_BYTES = 1'b0;
   localparam logic CSR_SEARCH_LIMIT = 1'b1;

   localparam logic [7:0] CHUNK_BYTES_RESET  = 8'd32;
   localparam logic [7:0] SEARCH_LIMIT_RESET = 8'd128;

   // Protocol bytes
   localparam logic [7:0] SYNC_BYTE      = 8'h76;
   localparam logic [7:0] ZERO_BYTE      = 8'h00;
   localparam logic [7:0] RESET_CODE     = 8'h26;
   localparam logic [7:0] SIZE_CODE      = 8'h34;
   localparam logic [7:0] DATA_CODE      = 8'h32;
   localparam logic [7:0] SIZE_LEN_BYTE  = 8'h04;
   localparam logic [7:0] MARK_LEAD      = 8'hFF;
   localparam logic [7:0] MARK_END       = 8'hD9;

   localparam logic [3:0] MSG_LEN    = 4'd10;
   localparam logic [7:0] FOOTER_LEN = 8'd5;

   typedef struct packed {
      logic       op;
      logic [1:0] response_kind;
      logic [7:0] ack_code;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  data_out;
      logic        data_keep;
      logic        done_res;
      logic [1:0]  status;
      logic [7:0]  chunk_count;
      logic        end_of_image;
      logic [15:0] image_size;
   } rsp_type;

   typedef struct packed {
      logic [7:0] chunk_bytes;
      logic [7:0] char_search_limit;
   } cfg_type;

   // Power-on message "Init end" CR LF
   function automatic logic [7:0] init_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = 8'h49;
         4'd1: c = 8'h6E;
         4'd2: c = 8'h69;
         4'd3: c = 8'h74;
         4'd4: c = 8'h20;
         4'd5: c = 8'h65;
         4'd6: c = 8'h6E;
         4'd7: c = 8'h64;
         4'd8: c = 8'h0D;
         4'd9: c = 8'h0A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Header length of each response kind
   function automatic logic [7:0] header_len(input logic [1:0] kind);
      logic [7:0] n;
      case (kind)
         KIND_RESET_ACK: n = 8'd4;
         KIND_BASIC_ACK: n = 8'd5;
         KIND_GET_SIZE:  n = 8'd7;
         default:        n = 8'd5;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// File: design/scrp_req_if.sv
// Input channel of the serial camera response parser: valid/ready plus one item.
// Depends on nothing.
`default_nettype none

interface scrp_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [1:0] response_kind;
   logic [7:0] ack_code;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output response_kind, output ack_code,
                   output rx_byte, input ready);
   modport sink   (input valid, input op, input response_kind, input ack_code,
                   input rx_byte, output ready);
endinterface

`default_nettype wire

// File: design/scrp_rsp_if.sv
// Result channel of the serial camera response parser: valid/ready plus one result.
// Depends on nothing.
`default_nettype none

interface scrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_out;
   logic        data_keep;
   logic        done_res;
   logic [1:0]  status;
   logic [7:0]  chunk_count;
   logic        end_of_image;
   logic [15:0] image_size;

   modport source (output valid, output data_out, output data_keep, output done_res,
                   output status, output chunk_count, output end_of_image,
                   output image_size, input ready);
   modport sink   (input valid, input data_out, input data_keep, input done_res,
                   input status, input chunk_count, input end_of_image,
                   input image_size, output ready);
endinterface

`default_nettype wire

// File: design/scrp_engine.sv
// Response parsing state machine: consumes one item per step and forms the result.
// Depends on scrp_pkg.
`default_nettype none

module scrp_engine
   import scrp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output logic         res_valid,
   output rsp_type      res
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_SEARCH, PH_SIZE, PH_PAYLOAD, PH_FOOTER
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] byte_index_ff, byte_index_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] code_ff, code_in;
   logic       header_ok_ff, header_ok_in;
   logic [7:0] previous_ff, previous_in;
   logic       marker_ff, marker_in;
   logic [7:0] image_count_ff, image_count_in;
   logic [7:0] size_high_ff, size_high_in;
   logic [3:0] msg_index_ff, msg_index_in;
   logic [7:0] search_count_ff, search_count_in;

   logic [7:0] expect_hdr;
   logic [7:0] expect_ftr;
   logic [8:0] index_next;
   logic [8:0] search_next;
   logic       hdr_ok_next;
   logic       ftr_ok_next;
   logic [7:0] b;

   assign b          = item.rx_byte;
   assign index_next = {1'b0, byte_index_ff} + 9'd1;
   assign search_next = {1'b0, search_count_ff} + 9'd1;

   // Expected header and footer byte at the current position
   always_comb begin
      case (byte_index_ff)
         8'd0: expect_hdr = SYNC_BYTE;
         8'd2: begin
            case (kind_ff)
               KIND_RESET_ACK: expect_hdr = RESET_CODE;
               KIND_BASIC_ACK: expect_hdr = code_ff;
               KIND_GET_SIZE:  expect_hdr = SIZE_CODE;
               default:        expect_hdr = DATA_CODE;
            endcase
         end
         8'd4:    expect_hdr = (kind_ff == KIND_GET_SIZE) ? SIZE_LEN_BYTE : ZERO_BYTE;
         default: expect_hdr = ZERO_BYTE;
      endcase
      case (byte_index_ff)
         8'd0:    expect_ftr = SYNC_BYTE;
         8'd2:    expect_ftr = DATA_CODE;
         default: expect_ftr = ZERO_BYTE;
      endcase
   end

   assign hdr_ok_next = header_ok_ff & (b == expect_hdr);
   assign ftr_ok_next = header_ok_ff & (b == expect_ftr);

   // Next state and result of one step
   always_comb begin
      phase_in        = phase_ff;
      byte_index_in   = byte_index_ff;
      kind_in         = kind_ff;
      code_in         = code_ff;
      header_ok_in    = header_ok_ff;
      previous_in     = previous_ff;
      marker_in       = marker_ff;
      image_count_in  = image_count_ff;
      size_high_in    = size_high_ff;
      msg_index_in    = msg_index_ff;
      search_count_in = search_count_ff;
      res_valid       = 1'b0;
      res             = '0;

      if (step_en) begin
         if (item.op == OP_START) begin
            // Arm a new response, dropping any in progress
            kind_in         = item.response_kind;
            code_in         = item.ack_code;
            phase_in        = PH_HEADER;
            byte_index_in   = '0;
            header_ok_in    = 1'b1;
            previous_in     = '0;
            marker_in       = 1'b0;
            image_count_in  = '0;
            size_high_in    = '0;
            msg_index_in    = '0;
            search_count_in = '0;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  header_ok_in = hdr_ok_next;
                  if (index_next < {1'b0, header_len(kind_ff)}) begin
                     byte_index_in = index_next[7:0];
                  end else begin
                     byte_index_in = '0;
                     if (!hdr_ok_next) begin
                        res_valid = 1'b1;
                        res.done_res = 1'b1;
                        res.status = STATUS_HEADER_BAD;
                        phase_in = PH_IDLE;
                     end else begin
                        case (kind_ff)
                           KIND_RESET_ACK: phase_in = PH_SEARCH;
                           KIND_BASIC_ACK: begin
                              res_valid = 1'b1;
                              res.done_res = 1'b1;
                              res.status = STATUS_OK;
                              phase_in = PH_IDLE;
                           end
                           KIND_GET_SIZE: phase_in = PH_SIZE;
                           default: phase_in = (cfg.chunk_bytes == 8'd0) ? PH_FOOTER
                                                                          : PH_PAYLOAD;
                        endcase
                     end
                  end
               end

               PH_SEARCH: begin
                  // Count the byte, then time out or match the next character
                  if (search_next > {1'b0, cfg.char_search_limit}) begin
                     res_valid = 1'b1;
                     res.done_res = 1'b1;
                     res.status = STATUS_INIT_TIMEOUT;
                     phase_in = PH_IDLE;
                  end else begin
                     search_count_in = search_next[7:0];
                     if (msg_index_ff < MSG_LEN && b == init_char(msg_index_ff)) begin
                        msg_index_in = msg_index_ff + 4'd1;
                        search_count_in = '0;
                        if (msg_index_ff + 4'd1 >= MSG_LEN) begin
                           res_valid = 1'b1;
                           res.done_res = 1'b1;
                           res.status = STATUS_OK;
                           phase_in = PH_IDLE;
                        end
                     end
                  end
               end

               PH_SIZE: begin
                  if (byte_index_ff == 8'd0) begin
                     size_high_in = b;
                     byte_index_in = 8'd1;
                  end else begin
                     res_valid = 1'b1;
                     res.done_res = 1'b1;
                     res.status = STATUS_OK;
                     res.image_size = {size_high_ff, b};
                     phase_in = PH_IDLE;
                  end
               end

               PH_PAYLOAD: begin
                  // Pass the byte through; keep it until the end marker has passed
                  if (byte_index_ff != 8'd0 && previous_ff == MARK_LEAD && b == MARK_END) begin
                     marker_in = 1'b1;
                  end
                  if (!marker_ff) begin
                     image_count_in = image_count_ff + 8'd1;
                  end
                  previous_in   = b;
                  res_valid     = 1'b1;
                  res.data_out  = b;
                  res.data_keep = ~marker_ff;
                  if (index_next >= {1'b0, cfg.chunk_bytes}) begin
                     byte_index_in = '0;
                     header_ok_in  = 1'b1;
                     phase_in      = PH_FOOTER;
                  end else begin
                     byte_index_in = index_next[7:0];
                  end
               end

               PH_FOOTER: begin
                  header_ok_in = ftr_ok_next;
                  if (index_next < {1'b0, FOOTER_LEN}) begin
                     byte_index_in = index_next[7:0];
                  end else begin
                     byte_index_in = '0;
                     res_valid = 1'b1;
                     res.done_res = 1'b1;
                     res.status = ftr_ok_next ? STATUS_OK : STATUS_FOOTER_BAD;
                     res.chunk_count = image_count_ff;
                     res.end_of_image = marker_ff;
                     phase_in = PH_IDLE;
                  end
               end

               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         byte_index_ff   <= '0;
         kind_ff         <= '0;
         code_ff         <= '0;
         header_ok_ff    <= 1'b1;
         previous_ff     <= '0;
         marker_ff       <= 1'b0;
         image_count_ff  <= '0;
         size_high_ff    <= '0;
         msg_index_ff    <= '0;
         search_count_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         byte_index_ff   <= byte_index_in;
         kind_ff         <= kind_in;
         code_ff         <= code_in;
         header_ok_ff    <= header_ok_in;
         previous_ff     <= previous_in;
         marker_ff       <= marker_in;
         image_count_ff  <= image_count_in;
         size_high_ff    <= size_high_in;
         msg_index_ff    <= msg_index_in;
         search_count_ff <= search_count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/serial_camera_response_parser.sv
// Serial camera response parser: top level with input stage, result stage and registers.
// Depends on scrp_pkg, scrp_req_if, scrp_rsp_if and scrp_engine.
//
// Usage:
//   req_chan carries one item per beat: a start (op 0) naming the expected
//   response, or one byte received from the camera (op 1).
//   rsp_chan carries at most one result per item: a payload byte passed
//   through during a data chunk, or a done result with status, chunk count,
//   end-of-image flag and picture size.
//   csr_* writes chunk_bytes (index 0) and char_search_limit (index 1);
//   write only while no item is in flight.
// Timing: an item is held in the input register and parsed into the result
//   register, so a result reaches rsp_chan through both registers. One item is
//   taken every cycle while rsp_chan.ready does not stall the result stage; the
//   per-byte compare and count logic is combinational between the two registers.
// Reset: synchronous; both stages empty, parser idle, registers at 32 and 128.
// Stall: while rsp_chan.ready is low a waiting result holds, the input
//   register fills, and then req_chan.ready drops until the result is taken.
`default_nettype none

module serial_camera_response_parser
   import scrp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   scrp_req_if.sink   req_chan,
   scrp_rsp_if.source rsp_chan,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_index,
   input  wire logic [7:0] csr_write_data
);

   cfg_type cfg_ff;
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    advance;
   logic    step_valid;
   rsp_type step_res;

   // Result stage can load when empty or being drained
   assign advance        = ~out_valid_ff | rsp_chan.ready;
   assign req_chan.ready = ~in_valid_ff | advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_bytes       <= CHUNK_BYTES_RESET;
         cfg_ff.char_search_limit <= SEARCH_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CHUNK_BYTES:  cfg_ff.chunk_bytes       <= csr_write_data;
            CSR_SEARCH_LIMIT: cfg_ff.char_search_limit <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Input stage: capture a beat whenever the stage is free or moving
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff.op            <= req_chan.op;
         in_data_ff.response_kind <= req_chan.response_kind;
         in_data_ff.ack_code      <= req_chan.ack_code;
         in_data_ff.rx_byte       <= req_chan.rx_byte;
      end
   end

   scrp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (in_valid_ff & advance),
      .item      (in_data_ff),
      .cfg       (cfg_ff),
      .res_valid (step_valid),
      .res       (step_res)
   );

   // Result stage: load on advance, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff & step_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff && step_valid) begin
         out_data_ff <= step_res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.data_out     = out_data_ff.data_out;
   assign rsp_chan.data_keep    = out_data_ff.data_keep;
   assign rsp_chan.done_res     = out_data_ff.done_res;
   assign rsp_chan.status       = out_data_ff.status;
   assign rsp_chan.chunk_count  = out_data_ff.chunk_count;
   assign rsp_chan.end_of_image = out_data_ff.end_of_image;
   assign rsp_chan.image_size   = out_data_ff.image_size;

endmodule

`default_nettype wire

// File: dv/serial_camera_response_parser_test.sv
// Self-checking testbench for the serial camera response parser.
// Holds a parse tracker (own model of the parser plus a queue of due results) and the test top.
// Depends on scrp_pkg, scrp_req_if, scrp_rsp_if and serial_camera_response_parser.

package scrp_test_pkg;
   import scrp_pkg::*;

   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_HEADER,
      PARSE_SEEK,
      PARSE_SIZE,
      PARSE_PAYLOAD,
      PARSE_FOOTER
   } parse_phase_type;

   // Power-on text the camera sends after a reset ack: "Init end" CR LF
   localparam logic [7:0] POWER_ON_TEXT [10] = '{8'h49, 8'h6E, 8'h69, 8'h74, 8'h20,
                                                8'h65, 8'h6E, 8'h64, 8'h0D, 8'h0A};

   class response_tracker;
      rsp_type         outputs_due[$];
      int unsigned     mismatches;
      int unsigned     parsed_items;
      logic [7:0]      chunk_len;
      logic [7:0]      seek_limit;
      parse_phase_type phase;
      logic [7:0]      byte_pos;
      logic [1:0]      kind;
      logic [7:0]      code;
      logic            header_good;
      logic [7:0]      last_byte;
      logic            marker;
      logic [7:0]      image_bytes;
      logic [7:0]      size_msb;
      logic [3:0]      text_pos;
      logic [7:0]      seek_count;

      function new();
         mismatches   = 0;
         parsed_items = 0;
         chunk_len    = CHUNK_BYTES_RESET;
         seek_limit   = SEARCH_LIMIT_RESET;
         phase        = PARSE_IDLE;
         byte_pos     = '0;
         kind         = '0;
         code         = '0;
         header_good  = 1'b1;
         last_byte    = '0;
         marker       = 1'b0;
         image_bytes  = '0;
         size_msb     = '0;
         text_pos     = '0;
         seek_count   = '0;
      endfunction

      function void write_register(logic idx, logic [7:0] value);
         if (idx == CSR_CHUNK_BYTES) chunk_len = value;
         else seek_limit = value;
      endfunction

      function int pending();
         return outputs_due.size();
      endfunction

      // Queue the done result and drop back to idle
      function void conclude(logic [1:0] status, logic [7:0] count, logic eoi,
                             logic [15:0] size);
         rsp_type r;
         r              = '0;
         r.done_res     = 1'b1;
         r.status       = status;
         r.chunk_count  = count;
         r.end_of_image = eoi;
         r.image_size   = size;
         outputs_due.push_back(r);
         phase = PARSE_IDLE;
      endfunction

      // Advance the parser by one accepted input beat
      function void note_request(req_type item);
         rsp_type    r;
         logic [7:0] b;
         logic [7:0] want;
         logic [7:0] hlen;
         logic [8:0] tally;
         logic       keep;
         b = item.rx_byte;
         if (item.op == OP_START) begin
            kind        = item.response_kind;
            code        = item.ack_code;
            phase       = PARSE_HEADER;
            byte_pos    = '0;
            header_good = 1'b1;
            last_byte   = '0;
            marker      = 1'b0;
            image_bytes = '0;
            size_msb    = '0;
            text_pos    = '0;
            seek_count  = '0;
            parsed_items++;
            return;
         end
         if (phase != PARSE_IDLE) parsed_items++;
         case (phase)
            PARSE_HEADER: begin
               want = ZERO_BYTE;
               if (byte_pos == 0) want = SYNC_BYTE;
               else if (byte_pos == 2) begin
                  case (kind)
                     KIND_RESET_ACK: want = RESET_CODE;
                     KIND_BASIC_ACK: want = code;
                     KIND_GET_SIZE:  want = SIZE_CODE;
                     default:        want = DATA_CODE;
                  endcase
               end else if (byte_pos == 4 && kind == KIND_GET_SIZE) want = SIZE_LEN_BYTE;
               if (b != want) header_good = 1'b0;
               byte_pos++;
               hlen = (kind == KIND_RESET_ACK) ? 8'd4 : (kind == KIND_GET_SIZE) ? 8'd7 : 8'd5;
               if (byte_pos >= hlen) begin
                  byte_pos = '0;
                  if (!header_good) conclude(STATUS_HEADER_BAD, '0, 1'b0, '0);
                  else begin
                     case (kind)
                        KIND_RESET_ACK: phase = PARSE_SEEK;
                        KIND_BASIC_ACK: conclude(STATUS_OK, '0, 1'b0, '0);
                        KIND_GET_SIZE:  phase = PARSE_SIZE;
                        default:        phase = (chunk_len == 0) ? PARSE_FOOTER : PARSE_PAYLOAD;
                     endcase
                  end
               end
            end
            // Count every byte first; a byte past the limit fails even if it matches
            PARSE_SEEK: begin
               tally = {1'b0, seek_count} + 9'd1;
               if (tally > {1'b0, seek_limit}) conclude(STATUS_INIT_TIMEOUT, '0, 1'b0, '0);
               else begin
                  seek_count = tally[7:0];
                  if (b == POWER_ON_TEXT[text_pos]) begin
                     text_pos++;
                     seek_count = '0;
                     if (text_pos == MSG_LEN) conclude(STATUS_OK, '0, 1'b0, '0);
                  end
               end
            end
            PARSE_SIZE: begin
               if (byte_pos == 0) begin
                  size_msb = b;
                  byte_pos = 8'd1;
               end else conclude(STATUS_OK, '0, 1'b0, {size_msb, b});
            end
            // Pass the byte through; the D9 of the marker is still kept and counted
            PARSE_PAYLOAD: begin
               keep = !marker;
               if (byte_pos != 0 && last_byte == MARK_LEAD && b == MARK_END) marker = 1'b1;
               if (keep) image_bytes++;
               last_byte   = b;
               r           = '0;
               r.data_out  = b;
               r.data_keep = keep;
               outputs_due.push_back(r);
               byte_pos++;
               if (byte_pos >= chunk_len) begin
                  byte_pos    = '0;
                  header_good = 1'b1;
                  phase       = PARSE_FOOTER;
               end
            end
            PARSE_FOOTER: begin
               want = (byte_pos == 0) ? SYNC_BYTE : (byte_pos == 2) ? DATA_CODE : ZERO_BYTE;
               if (b != want) header_good = 1'b0;
               byte_pos++;
               if (byte_pos >= FOOTER_LEN) begin
                  byte_pos = '0;
                  conclude(header_good ? STATUS_OK : STATUS_FOOTER_BAD, image_bytes, marker, '0);
               end
            end
            default: phase = PARSE_IDLE;
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // Match one accepted result beat against the oldest due result
      function void check_response(rsp_type got);
         rsp_type want;
         if (outputs_due.size() == 0) begin
            $display("%0t: result beat with none due, expected nothing, got %p", $time, got);
            mismatches++;
            return;
         end
         want = outputs_due.pop_front();
         compare_field("data_out", want.data_out, got.data_out);
         compare_field("data_keep", want.data_keep, got.data_keep);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("status", want.status, got.status);
         compare_field("chunk_count", want.chunk_count, got.chunk_count);
         compare_field("end_of_image", want.end_of_image, got.end_of_image);
         compare_field("image_size", want.image_size, got.image_size);
      endfunction
   endclass

endpackage

module serial_camera_response_parser_test;
   import scrp_pkg::*;
   import scrp_test_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD   = 120;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_index;
   logic [7:0] csr_write_data;

   bit calm         = 1'b0;
   bit hold_request = 1'b0;
   bit damaged      = 1'b0;
   bit cut          = 1'b0;

   response_tracker tracker;

   scrp_req_if req_chan();
   scrp_rsp_if rsp_chan();

   serial_camera_response_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watch both channels
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         tracker.note_request(req_type'({req_chan.op, req_chan.response_kind,
                                         req_chan.ack_code, req_chan.rx_byte}));
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_response(rsp_type'({rsp_chan.data_out, rsp_chan.data_keep,
                                           rsp_chan.done_res, rsp_chan.status,
                                           rsp_chan.chunk_count, rsp_chan.end_of_image,
                                           rsp_chan.image_size}));
   end

   // Result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offer one beat, idling first now and then; return at the accepting edge
   task automatic send_item(input logic op, input logic [1:0] kind, input logic [7:0] code,
                            input logic [7:0] data);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.op            <= op;
      req_chan.response_kind <= kind;
      req_chan.ack_code      <= code;
      req_chan.rx_byte       <= data;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_start(input logic [1:0] kind, input logic [7:0] code);
      send_item(OP_START, kind, code, 8'($urandom));
   endtask

   // Received byte; a damaged response may get a flipped byte or stop short
   task automatic send_rx(input logic [7:0] data);
      logic [7:0] b;
      b = data;
      if (damaged && $urandom_range(0, 30) == 0) cut = 1'b1;
      if (cut) return;
      if (damaged && $urandom_range(0, 11) == 0) b = b ^ 8'($urandom_range(1, 255));
      send_item(OP_BYTE, 2'($urandom), 8'($urandom), b);
   endtask

   // Data chunk header and footer carry the same five bytes
   task automatic send_chunk_frame();
      send_rx(SYNC_BYTE);
      send_rx(ZERO_BYTE);
      send_rx(DATA_CODE);
      send_rx(ZERO_BYTE);
      send_rx(ZERO_BYTE);
   endtask

   // Drop valid, wait for every due result, then let in-flight beats clear
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.write_register(idx, value);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0:       b = 8'h00;
         1:       b = MARK_LEAD;
         2:       b = MARK_END;
         default: b = 8'($urandom);
      endcase
      return b;
   endfunction

   // One response of a random kind with random content
   task automatic send_response();
      logic [1:0] kind;
      logic [7:0] code;
      logic [7:0] limit;
      logic [7:0] chunk;
      int         junk;
      int         marker_at;
      kind = ($urandom_range(0, 2) == 0) ? KIND_DATA : 2'($urandom_range(0, 3));
      code    = 8'($urandom);
      limit   = tracker.seek_limit;
      chunk   = tracker.chunk_len;
      damaged = ($urandom_range(0, 7) == 0);
      cut     = 1'b0;
      send_start(kind, code);
      case (kind)
         KIND_RESET_ACK: begin
            send_rx(SYNC_BYTE);
            send_rx(ZERO_BYTE);
            send_rx(RESET_CODE);
            send_rx(ZERO_BYTE);
            // Noise before each character; now and then exactly enough to run out
            for (int i = 0; i < 10; i++) begin
               junk = 0;
               if (limit != 0) junk = $urandom_range(0, (limit > 4) ? 3 : limit - 1);
               if (limit < 16 && $urandom_range(0, 24) == 0) junk = limit;
               repeat (junk) send_rx(8'($urandom));
               send_rx(POWER_ON_TEXT[i]);
            end
         end
         KIND_BASIC_ACK: begin
            send_rx(SYNC_BYTE);
            send_rx(ZERO_BYTE);
            send_rx(code);
            send_rx(ZERO_BYTE);
            send_rx(ZERO_BYTE);
         end
         KIND_GET_SIZE: begin
            send_rx(SYNC_BYTE);
            send_rx(ZERO_BYTE);
            send_rx(SIZE_CODE);
            send_rx(ZERO_BYTE);
            send_rx(SIZE_LEN_BYTE);
            send_rx(ZERO_BYTE);
            send_rx(ZERO_BYTE);
            send_rx(pick_byte());
            send_rx(pick_byte());
         end
         default: begin
            send_chunk_frame();
            if (chunk >= 2 && $urandom_range(0, 1) == 1) marker_at = $urandom_range(0, chunk - 2);
            else marker_at = -1;
            for (int i = 0; i < chunk; i++) begin
               if (i == marker_at) send_rx(MARK_LEAD);
               else if (marker_at >= 0 && i == marker_at + 1) send_rx(MARK_END);
               else send_rx(pick_byte());
            end
            send_chunk_frame();
         end
      endcase
      damaged = 1'b0;
      cut     = 1'b0;
   endtask

   initial begin
      logic [7:0]  chunk_pick;
      logic [7:0]  limit_pick;
      int          setting;
      int unsigned random_base;
      tracker = new();
      req_chan.valid         <= 1'b0;
      req_chan.op            <= OP_START;
      req_chan.response_kind <= KIND_RESET_ACK;
      req_chan.ack_code      <= 8'h00;
      req_chan.rx_byte       <= 8'h00;
      csr_write_enable       <= 1'b0;
      csr_index              <= CSR_CHUNK_BYTES;
      csr_write_data         <= 8'h00;
      reset                  <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle byte, restart, marker at the first two payload bytes,
      // chunk shortened mid-payload, basic ack with an all-ones code
      write_register(CSR_CHUNK_BYTES, 8'd4);
      send_item(OP_BYTE, KIND_DATA, 8'h00, 8'hFF);
      send_start(KIND_DATA, 8'h00);
      send_rx(SYNC_BYTE);
      send_start(KIND_DATA, 8'hFF);
      send_chunk_frame();
      send_rx(MARK_LEAD);
      send_rx(MARK_END);
      settle();
      write_register(CSR_CHUNK_BYTES, 8'd1);
      send_rx(8'h07);
      send_chunk_frame();
      send_start(KIND_BASIC_ACK, 8'hFF);
      send_rx(SYNC_BYTE);
      send_rx(ZERO_BYTE);
      send_rx(8'hFF);
      send_rx(ZERO_BYTE);
      send_rx(ZERO_BYTE);

      // Random: cycle through register settings, reset values first, then small ones, longest chunk last
      random_base = tracker.parsed_items;
      setting     = 0;
      while (tracker.parsed_items - random_base < 450) begin
         case (setting % 6)
            0: begin
               chunk_pick = CHUNK_BYTES_RESET;
               limit_pick = SEARCH_LIMIT_RESET;
            end
            1: begin
               chunk_pick = 8'd1;
               limit_pick = 8'd1;
            end
            2: begin
               chunk_pick = 8'd0;
               limit_pick = 8'd0;
            end
            3: begin
               chunk_pick = 8'd3;
               limit_pick = 8'd2;
            end
            4: begin
               chunk_pick = 8'($urandom_range(0, 12));
               limit_pick = 8'($urandom_range(0, 6));
            end
            default: begin
               chunk_pick = 8'd255;
               limit_pick = 8'd255;
            end
         endcase
         settle();
         write_register(CSR_CHUNK_BYTES, chunk_pick);
         write_register(CSR_SEARCH_LIMIT, limit_pick);
         // Starve the result side once while beats keep coming
         if (setting == 0) hold_request = 1'b1;
         for (int n = 0; n < ((chunk_pick > 64) ? 1 : 4); n++) begin
            if (tracker.parsed_items - random_base >= 450) break;
            if ($urandom_range(0, 19) == 0)
               repeat ($urandom_range(1, 6))
                  send_item(1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
            else send_response();
            if (tracker.parsed_items - random_base > 380) calm = 1'b1;
         end
         setting++;
      end

      settle();
      if (tracker.mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
